// File: design/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg: shared types and constants for the indexed list engine
// Holds operation codes, status codes, controller states and the command
// and status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

	// Default sizing of the element store.
	localparam int CAPACITY_DEF   = 256;
	localparam int DATA_WIDTH_DEF = 32;

	// Operation codes carried in the kind field.
	typedef enum logic [2:0] {
		KIND_PUSH_FRONT = 3'd0,
		KIND_PUSH_BACK  = 3'd1,
		KIND_INSERT_AT  = 3'd2,
		KIND_POP_FRONT  = 3'd3,
		KIND_POP_BACK   = 3'd4,
		KIND_REMOVE_AT  = 3'd5,
		KIND_GET        = 3'd6,
		KIND_SET        = 3'd7
	} kind_t;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Controller states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_PAD,
		S_SHUP_RD,
		S_SHUP_WR,
		S_WR_VAL,
		S_WR_FRONT,
		S_WR_SET,
		S_RD_REQ,
		S_RD_CAP,
		S_SHDN_RD,
		S_SHDN_WR,
		S_SHRINK,
		S_FIN
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic decode;
		logic pad_wr;
		logic shup_rd;
		logic shup_wr;
		logic val_wr;
		logic front_wr;
		logic set_wr;
		logic rd_req;
		logic rd_cap;
		logic shdn_rd;
		logic shdn_wr;
		logic shrink;
		logic fin_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic range;
		logic front;
		logic set_in;
		logic grow;
		logic pad_need;
		logic shup_need;
		logic pad_last;
		logic shup_last;
		logic shdn_need;
		logic shdn_last;
		logic is_get;
		logic is_remove;
		logic slot_free;
	} sts_t;

endpackage

`default_nettype wire

// File: design/ile_ram.sv
// ----------------------------------------------------------------------------
// ile_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: design/ile_ctrl.sv
// ----------------------------------------------------------------------------
// ile_ctrl: controller state machine of the indexed list engine
// Sequences padding, shifting, reads and writes of one operation and
// hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire ile_pkg::sts_t sts,
	output ile_pkg::cmd_t      cmd,
	output logic               busy
);

	ile_pkg::state_t state_q;
	ile_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ile_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ile_pkg::S_IDLE: begin
				if (in_valid) state_d = ile_pkg::S_DECODE;
			end
			ile_pkg::S_DECODE: begin
				if (sts.full || sts.range) state_d = ile_pkg::S_FIN;
				else if (sts.front) state_d = ile_pkg::S_WR_FRONT;
				else if (sts.set_in) state_d = ile_pkg::S_WR_SET;
				else if (sts.grow) begin
					if (sts.pad_need) state_d = ile_pkg::S_PAD;
					else if (sts.shup_need) state_d = ile_pkg::S_SHUP_RD;
					else state_d = ile_pkg::S_WR_VAL;
				end else state_d = ile_pkg::S_RD_REQ;
			end
			ile_pkg::S_PAD: begin
				if (sts.pad_last) state_d = ile_pkg::S_WR_VAL;
			end
			ile_pkg::S_SHUP_RD: state_d = ile_pkg::S_SHUP_WR;
			ile_pkg::S_SHUP_WR: begin
				state_d = sts.shup_last ? ile_pkg::S_WR_VAL : ile_pkg::S_SHUP_RD;
			end
			ile_pkg::S_WR_VAL:   state_d = ile_pkg::S_FIN;
			ile_pkg::S_WR_FRONT: state_d = ile_pkg::S_FIN;
			ile_pkg::S_WR_SET:   state_d = ile_pkg::S_FIN;
			ile_pkg::S_RD_REQ:   state_d = ile_pkg::S_RD_CAP;
			ile_pkg::S_RD_CAP: begin
				if (sts.is_get) state_d = ile_pkg::S_FIN;
				else if (sts.is_remove && sts.shdn_need) state_d = ile_pkg::S_SHDN_RD;
				else state_d = ile_pkg::S_SHRINK;
			end
			ile_pkg::S_SHDN_RD: state_d = ile_pkg::S_SHDN_WR;
			ile_pkg::S_SHDN_WR: begin
				state_d = sts.shdn_last ? ile_pkg::S_SHRINK : ile_pkg::S_SHDN_RD;
			end
			ile_pkg::S_SHRINK: state_d = ile_pkg::S_FIN;
			ile_pkg::S_FIN: begin
				if (sts.slot_free) state_d = ile_pkg::S_IDLE;
			end
			default: state_d = ile_pkg::S_IDLE;
		endcase
	end

	// Command outputs.
	always_comb begin
		cmd  = '0;
		busy = (state_q != ile_pkg::S_IDLE);
		case (state_q)
			ile_pkg::S_IDLE:     cmd.load_item = in_valid;
			ile_pkg::S_DECODE:   cmd.decode    = 1'b1;
			ile_pkg::S_PAD:      cmd.pad_wr    = 1'b1;
			ile_pkg::S_SHUP_RD:  cmd.shup_rd   = 1'b1;
			ile_pkg::S_SHUP_WR:  cmd.shup_wr   = 1'b1;
			ile_pkg::S_WR_VAL:   cmd.val_wr    = 1'b1;
			ile_pkg::S_WR_FRONT: cmd.front_wr  = 1'b1;
			ile_pkg::S_WR_SET:   cmd.set_wr    = 1'b1;
			ile_pkg::S_RD_REQ:   cmd.rd_req    = 1'b1;
			ile_pkg::S_RD_CAP:   cmd.rd_cap    = 1'b1;
			ile_pkg::S_SHDN_RD:  cmd.shdn_rd   = 1'b1;
			ile_pkg::S_SHDN_WR:  cmd.shdn_wr   = 1'b1;
			ile_pkg::S_SHRINK:   cmd.shrink    = 1'b1;
			ile_pkg::S_FIN:      cmd.fin_load  = sts.slot_free;
			default:             cmd           = '0;
		endcase
	end

endmodule

`default_nettype wire

// File: design/ile_dpath.sv
// ----------------------------------------------------------------------------
// ile_dpath: datapath of the indexed list engine
// Holds the item, the count, the ring head, the walk pointer, the element
// RAM and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_dpath #(
	parameter int CAPACITY   = ile_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ile_pkg::cmd_t      cmd,
	output ile_pkg::sts_t           sts,
	input  wire logic [2:0]         kind,
	input  wire logic [7:0]         position,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      read_value,
	output logic [1:0]              status,
	output logic [8:0]              element_count
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > 8) ? CW : 8) + 1;

	ile_pkg::kind_t          kind_q;
	logic [7:0]              pos_q;
	logic [DATA_WIDTH-1:0]   val_q;
	logic [CW-1:0]           cnt_q;
	logic [AW-1:0]           head_q;
	logic [CW-1:0]           cur_q;
	logic [CW-1:0]           tp_q;
	logic [1:0]              st_q;
	logic [DATA_WIDTH-1:0]   rd_q;
	logic                    out_valid_q;
	logic signed [31:0]      out_rv_q;
	logic [1:0]              out_st_q;
	logic [8:0]              out_cnt_q;

	logic [XW-1:0]           pos_x;
	logic [XW-1:0]           cnt_x;
	logic [XW-1:0]           cap_x;
	logic [XW-1:0]           tp_x;
	logic [XW-1:0]           max_x;
	logic [AW-1:0]           head_m1;
	logic [AW-1:0]           head_p1;
	logic                    we;
	logic [AW-1:0]           waddr;
	logic [AW-1:0]           raddr;
	logic [DATA_WIDTH-1:0]   wdata;
	logic [DATA_WIDTH-1:0]   rdata;
	logic [1:0]              st_d;

	// Logical index to RAM address around the ring.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = (CW+1)'(hd) + (CW+1)'(i);
		if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
		return AW'(s);
	endfunction

	// Decode of the registered item against the current count.
	always_comb begin
		pos_x = XW'(pos_q);
		cnt_x = XW'(cnt_q);
		cap_x = XW'(CAPACITY);
		max_x = (pos_x > cnt_x) ? pos_x : cnt_x;
		case (kind_q)
			ile_pkg::KIND_PUSH_BACK: tp_x = cnt_x;
			ile_pkg::KIND_POP_FRONT: tp_x = '0;
			ile_pkg::KIND_POP_BACK:  tp_x = cnt_x - XW'(1);
			default:                 tp_x = pos_x;
		endcase

		sts.front  = (kind_q == ile_pkg::KIND_PUSH_FRONT) ||
		             (kind_q == ile_pkg::KIND_INSERT_AT && pos_q == 8'd0);
		sts.set_in = (kind_q == ile_pkg::KIND_SET) && (pos_x < cnt_x);
		sts.grow   = (kind_q == ile_pkg::KIND_PUSH_BACK) ||
		             (kind_q == ile_pkg::KIND_INSERT_AT && pos_q != 8'd0) ||
		             (kind_q == ile_pkg::KIND_SET && pos_x >= cnt_x);
		sts.full   = ((kind_q == ile_pkg::KIND_PUSH_FRONT ||
		               kind_q == ile_pkg::KIND_PUSH_BACK) && cnt_x >= cap_x) ||
		             (kind_q == ile_pkg::KIND_INSERT_AT && max_x + XW'(1) > cap_x) ||
		             (kind_q == ile_pkg::KIND_SET && pos_x >= cnt_x &&
		              pos_x + XW'(1) > cap_x);
		sts.range  = ((kind_q == ile_pkg::KIND_POP_FRONT ||
		               kind_q == ile_pkg::KIND_POP_BACK) && cnt_q == '0) ||
		             ((kind_q == ile_pkg::KIND_REMOVE_AT ||
		               kind_q == ile_pkg::KIND_GET) && pos_x >= cnt_x);
		sts.pad_need  = tp_x > cnt_x;
		sts.shup_need = tp_x < cnt_x;
		sts.pad_last  = (cur_q + CW'(1)) == tp_q;
		sts.shup_last = (cur_q - CW'(1)) == tp_q;
		sts.shdn_need = ((CW+1)'(tp_q) + (CW+1)'(1)) < (CW+1)'(cnt_q);
		sts.shdn_last = ((CW+1)'(cur_q) + (CW+1)'(2)) == (CW+1)'(cnt_q);
		sts.is_get    = (kind_q == ile_pkg::KIND_GET);
		sts.is_remove = (kind_q == ile_pkg::KIND_REMOVE_AT);
		sts.slot_free = !out_valid_q || !out_stall;

		if (sts.full) st_d = ile_pkg::ST_FULL;
		else if (sts.range) st_d = ile_pkg::ST_RANGE;
		else st_d = ile_pkg::ST_OK;
	end

	// Ring head neighbors.
	assign head_m1 = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
	assign head_p1 = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);

	// RAM port selection.
	always_comb begin
		we    = cmd.pad_wr || cmd.shup_wr || cmd.shdn_wr || cmd.val_wr ||
		        cmd.set_wr || cmd.front_wr;
		waddr = phys(head_q, cur_q);
		if (cmd.val_wr || cmd.set_wr) waddr = phys(head_q, tp_q);
		else if (cmd.front_wr) waddr = head_m1;
		wdata = val_q;
		if (cmd.pad_wr) wdata = '0;
		else if (cmd.shup_wr || cmd.shdn_wr) wdata = rdata;
		raddr = phys(head_q, tp_q);
		if (cmd.shup_rd) raddr = phys(head_q, cur_q - CW'(1));
		else if (cmd.shdn_rd) raddr = phys(head_q, cur_q + CW'(1));
	end

	ile_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Item, walk pointer and read result registers.
	// A remove walks down from its index; padding and moves up start at the end.
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= ile_pkg::kind_t'(kind);
			pos_q  <= position;
			val_q  <= DATA_WIDTH'(value);
		end
		if (cmd.decode) begin
			tp_q  <= tp_x[CW-1:0];
			cur_q <= (kind_q == ile_pkg::KIND_REMOVE_AT) ? tp_x[CW-1:0] : cnt_q;
			st_q  <= st_d;
			rd_q  <= '0;
		end
		if (cmd.pad_wr || cmd.shdn_wr) cur_q <= cur_q + CW'(1);
		if (cmd.shup_wr) cur_q <= cur_q - CW'(1);
		if (cmd.rd_cap) rd_q <= rdata;
	end

	// Count and ring head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			head_q <= '0;
		end else begin
			if (cmd.pad_wr || cmd.val_wr || cmd.front_wr) cnt_q <= cnt_q + CW'(1);
			if (cmd.shrink) cnt_q <= cnt_q - CW'(1);
			if (cmd.front_wr) head_q <= head_m1;
			if (cmd.shrink && kind_q == ile_pkg::KIND_POP_FRONT) head_q <= head_p1;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.fin_load) begin
			out_rv_q  <= 32'(signed'(rd_q));
			out_st_q  <= st_q;
			out_cnt_q <= 9'(cnt_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign read_value    = out_rv_q;
	assign status        = out_st_q;
	assign element_count = out_cnt_q;

endmodule

`default_nettype wire

// File: design/indexed_list_engine_top.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_top: ordered list of signed values with indexed access
// Push, pop, insert, remove, get and set on a ring-buffered element RAM.
// ----------------------------------------------------------------------------
//  Channel | Handshake           | Payload
//  input   | in_valid, in_stall  | kind, position, value
//  output  | out_valid, out_stall| read_value, status, element_count
//
// One item at a time: an accepting idle cycle, decode, RAM steps, a final state.
// Push, set and insert with nothing moved write once, get reads, pops read
// and shrink, a rejected item goes straight to the final state; insert pads
// zeros or moves entries up, and remove at an index moves entries down.
// Reset clears the count, ring head and control; RAM contents are not cleared.
// A new item is accepted while a finished result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine_top #(
	parameter int CAPACITY   = ile_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = ile_pkg::DATA_WIDTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [2:0]         kind,
	input  wire logic [7:0]         position,
	input  wire logic signed [31:0] value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      read_value,
	output logic [1:0]              status,
	output logic [8:0]              element_count
);

	ile_pkg::cmd_t cmd;
	ile_pkg::sts_t sts;
	logic          busy;

	ile_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.sts     (sts),
		.cmd     (cmd),
		.busy    (busy)
	);

	ile_dpath #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.position     (position),
		.value        (value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.read_value   (read_value),
		.status       (status),
		.element_count(element_count)
	);

	// Input transfers are taken only when the controller is idle.
	assign in_stall = busy;

endmodule

`default_nettype wire

// File: design/ile_props.sv
// ----------------------------------------------------------------------------
// ile_props: port-level properties of the indexed list engine
// Checks result transfers seen on the top-level ports, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_props #(
	parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [31:0] read_value,
	input wire logic [1:0]  status,
	input wire logic [8:0]  element_count
);

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(read_value) && $stable(status) &&
		$stable(element_count))
		else $error("result changed while stalled");

	// Failed operations read nothing.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ile_pkg::ST_OK |-> read_value == 32'd0)
		else $error("failed operation returned data");

	// Status is one of the defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == ile_pkg::ST_OK || status == ile_pkg::ST_RANGE ||
		status == ile_pkg::ST_FULL)
		else $error("undefined status code");

	// The count never exceeds the capacity.
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(element_count) <= 32'(CAPACITY))
		else $error("element count above capacity");

endmodule

bind indexed_list_engine_top ile_props #(.CAPACITY(CAPACITY)) u_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.read_value   (read_value),
	.status       (status),
	.element_count(element_count)
);

`default_nettype wire

// File: tb/sv/indexed_list_engine_top_tb.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_top_tb: self-checking bench for the indexed list engine
// A directed table covers the list ends, padding, range and full cases; then
// random list operations run against a behavioral list with random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_engine_top_tb;

	localparam int CAP        = 256;
	localparam int RAND_ITEMS = 2000;
	localparam int MAX_CYCLES = 10000000;

	// One row of the directed table; chk marks a typed-in expectation.
	typedef struct {
		ile_pkg::kind_t op;
		logic [7:0]     pos;
		logic [31:0]    val;
		logic           chk;
		logic [31:0]    rd;
		logic [1:0]     st;
		logic [8:0]     cnt;
	} row_t;

	typedef struct {
		logic [31:0] rd;
		logic [1:0]  st;
		logic [8:0]  cnt;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] kind = '0;
	logic [7:0] position = '0;
	logic signed [31:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] read_value;
	logic [1:0] status;
	logic [8:0] element_count;

	// Behavioral copy of the list contents and length.
	logic [31:0] list_vals[CAP];
	int unsigned list_len;
	outcome_t pending[$];
	int errors = 0;
	int cycles = 0;
	bit quiet = 1'b0;
	bit long_hold = 1'b0;
	bit hold_done = 1'b0;

	indexed_list_engine_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .position(position), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.read_value(read_value), .status(status), .element_count(element_count)
	);

	always #5 clk = ~clk;

	// Place a value at index p, padding with zeros past the end.
	function automatic void list_place(input int unsigned p, input logic [31:0] v);
		while (list_len < p) begin
			list_vals[list_len] = '0;
			list_len++;
		end
		for (int i = int'(list_len); i > int'(p); i--)
			list_vals[i] = list_vals[i - 1];
		list_vals[p] = v;
		list_len++;
	endfunction

	function automatic void list_take(input int unsigned p, output logic [31:0] v);
		v = list_vals[p];
		for (int unsigned i = p; i + 1 < list_len; i++)
			list_vals[i] = list_vals[i + 1];
		list_len--;
	endfunction

	// Apply one operation to the list and return what the block should report.
	function automatic outcome_t list_apply(ile_pkg::kind_t op, logic [7:0] pos,
	                                        logic [31:0] v);
		outcome_t o;
		int unsigned p;
		o.rd = '0;
		o.st = ile_pkg::ST_OK;
		p = pos;
		case (op)
			ile_pkg::KIND_PUSH_FRONT, ile_pkg::KIND_PUSH_BACK: begin
				if (list_len >= CAP) o.st = ile_pkg::ST_FULL;
				else list_place(op == ile_pkg::KIND_PUSH_FRONT ? 0 : list_len, v);
			end
			ile_pkg::KIND_INSERT_AT: begin
				if (((p > list_len) ? p : list_len) + 1 > CAP) o.st = ile_pkg::ST_FULL;
				else list_place(p, v);
			end
			ile_pkg::KIND_POP_FRONT, ile_pkg::KIND_POP_BACK: begin
				if (list_len == 0) o.st = ile_pkg::ST_RANGE;
				else list_take(op == ile_pkg::KIND_POP_FRONT ? 0 : list_len - 1, o.rd);
			end
			ile_pkg::KIND_REMOVE_AT: begin
				if (p >= list_len) o.st = ile_pkg::ST_RANGE;
				else list_take(p, o.rd);
			end
			ile_pkg::KIND_GET: begin
				if (p >= list_len) o.st = ile_pkg::ST_RANGE;
				else o.rd = list_vals[p];
			end
			default: begin
				if (p < list_len) list_vals[p] = v;
				else if (p + 1 > CAP) o.st = ile_pkg::ST_FULL;
				else list_place(p, v);
			end
		endcase
		o.cnt = list_len[8:0];
		return o;
	endfunction

	// Offer one transfer and record the expected outcome once it is accepted.
	// Rows with a typed-in expectation are checked against that expectation.
	task automatic send(ile_pkg::kind_t op, logic [7:0] pos, logic [31:0] v, bit chk,
	                    outcome_t typed);
		outcome_t o;
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		position <= pos;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		o = list_apply(op, pos, v);
		pending.push_back(chk ? typed : o);
	endtask

	// Receiver side: random stall bursts, plus one long hold-off.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (long_hold && !hold_done) begin
				out_stall <= 1'b1;
				repeat (600) @(posedge clk);
				hold_done = 1'b1;
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 12);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				@(posedge clk);
			end
		end
	end

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending.size() == 0) begin
				$error("result with no expectation waiting");
				errors++;
			end else begin
				e = pending.pop_front();
				if (read_value !== e.rd) begin
					$error("read_value: expected %h, actual %h", e.rd, read_value);
					errors++;
				end
				if (status !== e.st) begin
					$error("status: expected %0d, actual %0d", e.st, status);
					errors++;
				end
				if (element_count !== e.cnt) begin
					$error("element_count: expected %0d, actual %0d", e.cnt, element_count);
					errors++;
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Pick a random operation, mostly keeping positions near the list length.
	task automatic random_item();
		ile_pkg::kind_t op;
		logic [7:0] pos;
		logic [31:0] v;
		int r;
		op = ile_pkg::kind_t'($urandom_range(0, 7));
		r = $urandom_range(0, 9);
		if (r < 6) pos = 8'($urandom_range(0, list_len + 2 > 255 ? 255 : list_len + 2));
		else pos = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 3))
			0: v = 32'h8000_0000;
			1: v = 32'h7FFF_FFFF;
			default: v = $urandom;
		endcase
		send(op, pos, v, 1'b0, '{default: '0});
	endtask

	initial begin
		row_t tbl[$];
		outcome_t typed;
		int wait_cnt;
		list_len = 0;
		// Directed rows: empty-list errors, extremes, padding and every operation.
		tbl = '{
			'{ile_pkg::KIND_POP_FRONT, 8'd0, 32'd0, 1, 32'd0, ile_pkg::ST_RANGE, 9'd0},
			'{ile_pkg::KIND_POP_BACK, 8'd0, 32'd0, 1, 32'd0, ile_pkg::ST_RANGE, 9'd0},
			'{ile_pkg::KIND_GET, 8'd0, 32'd0, 1, 32'd0, ile_pkg::ST_RANGE, 9'd0},
			'{ile_pkg::KIND_REMOVE_AT, 8'd255, 32'd0, 1, 32'd0, ile_pkg::ST_RANGE, 9'd0},
			'{ile_pkg::KIND_PUSH_BACK, 8'd0, 32'h7FFF_FFFF, 1, 32'd0, ile_pkg::ST_OK, 9'd1},
			'{ile_pkg::KIND_PUSH_FRONT, 8'd0, 32'h8000_0000, 1, 32'd0, ile_pkg::ST_OK, 9'd2},
			'{ile_pkg::KIND_GET, 8'd0, 32'd0, 1, 32'h8000_0000, ile_pkg::ST_OK, 9'd2},
			'{ile_pkg::KIND_INSERT_AT, 8'd1, 32'h1234_5678, 0, 0, 0, 0},
			'{ile_pkg::KIND_INSERT_AT, 8'd6, 32'hFFFF_FFFF, 0, 0, 0, 0},
			'{ile_pkg::KIND_INSERT_AT, 8'd0, 32'h0000_0001, 0, 0, 0, 0},
			'{ile_pkg::KIND_SET, 8'd2, 32'hAAAA_5555, 0, 0, 0, 0},
			'{ile_pkg::KIND_SET, 8'd10, 32'h5555_AAAA, 0, 0, 0, 0},
			'{ile_pkg::KIND_GET, 8'd5, 32'd0, 0, 0, 0, 0},
			'{ile_pkg::KIND_REMOVE_AT, 8'd3, 32'd0, 0, 0, 0, 0},
			'{ile_pkg::KIND_POP_BACK, 8'd0, 32'd0, 0, 0, 0, 0},
			'{ile_pkg::KIND_POP_FRONT, 8'd0, 32'd0, 0, 0, 0, 0},
			'{ile_pkg::KIND_GET, 8'd200, 32'd0, 0, 0, 0, 0},
			'{ile_pkg::KIND_SET, 8'd255, 32'hDEAD_BEEF, 0, 0, 0, 0},
			'{ile_pkg::KIND_PUSH_BACK, 8'd0, 32'd7, 1, 32'd0, ile_pkg::ST_FULL, 9'd256},
			'{ile_pkg::KIND_INSERT_AT, 8'd0, 32'd7, 1, 32'd0, ile_pkg::ST_FULL, 9'd256},
			'{ile_pkg::KIND_SET, 8'd255, 32'd9, 0, 0, 0, 0},
			'{ile_pkg::KIND_GET, 8'd255, 32'd0, 1, 32'd9, ile_pkg::ST_OK, 9'd256},
			'{ile_pkg::KIND_POP_BACK, 8'd0, 32'd0, 1, 32'd9, ile_pkg::ST_OK, 9'd255},
			'{ile_pkg::KIND_INSERT_AT, 8'd255, 32'd3, 0, 0, 0, 0},
			'{ile_pkg::KIND_REMOVE_AT, 8'd255, 32'd0, 0, 0, 0, 0}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (tbl[i]) begin
			typed = '{tbl[i].rd, tbl[i].st, tbl[i].cnt};
			send(tbl[i].op, tbl[i].pos, tbl[i].val, tbl[i].chk, typed);
		end
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == 300) long_hold = 1'b1;
			if (i == RAND_ITEMS - 200) quiet = 1'b1;
			random_item();
		end
		in_valid <= 1'b0;
		wait_cnt = 0;
		while (pending.size() != 0 && wait_cnt < 200000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (50) @(posedge clk);
		if (errors == 0 && pending.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// File: files.f
design/ile_pkg.sv
design/ile_ram.sv
design/ile_ctrl.sv
design/ile_dpath.sv
design/indexed_list_engine_top.sv
design/ile_props.sv
tb/sv/indexed_list_engine_top_tb.sv
